FILE: rtl/permutation_table_with_inverse_macros.svh
// Assertion macros for the permutation table checker.
// Needs clock and reset in the scope of each use; no other dependencies.
`ifndef PERMUTATION_TABLE_WITH_INVERSE_MACROS_SVH
`define PERMUTATION_TABLE_WITH_INVERSE_MACROS_SVH

// same-cycle implication, masked during reset
`define PTI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define PTI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication checked at every edge, reset included
`define PTI_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pti_pkg.sv
// Types and constants shared by the permutation table design.
// No dependencies.
package pti_pkg;

   localparam int REQ_W     = 2;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 6;
   localparam int CFG_W     = 7;
   localparam int ST_W      = 2;
   localparam int MAX_CELLS = 64;

   localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_SWAP  = 2'd1,
      REQ_MOVE  = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   typedef enum logic [ST_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_ORDER = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_INIT,
      UPD_SWAP,
      UPD_MOVE
   } upd_kind_type;

   // broadcast to every cell during the update cycle
   typedef struct packed {
      upd_kind_type kind;
      pos_type      a;
      pos_type      b;
      val_type      fwd_a;
      val_type      fwd_b;
   } upd_type;

endpackage

FILE: rtl/pti_channels.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on pti_pkg.
interface pti_req_if;
   logic                       valid;
   logic                       ready;
   logic [pti_pkg::REQ_W-1:0]  req_type;
   pti_pkg::pos_type           pos_a;
   pti_pkg::pos_type           pos_b;

   modport source (output valid, output req_type, output pos_a, output pos_b, input ready);
   modport sink   (input valid, input req_type, input pos_a, input pos_b, output ready);
endinterface

interface pti_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pti_pkg::ST_W-1:0]   status;
   pti_pkg::val_type           value_at_a;
   pti_pkg::pos_type           place_of_a;

   modport source (output valid, output status, output value_at_a, output place_of_a,
                   input ready);
   modport sink   (input valid, input status, input value_at_a, input place_of_a,
                   output ready);
endinterface

FILE: rtl/permutation_table_with_inverse.sv
// Top level: request sequencer, size register and the row of cells.
// Depends on pti_pkg, pti_channels, pti_cell and pti_select.
//
//  port       dir   beat carries
//  req_bus    in    req_type, pos_a, pos_b
//  rsp_bus    out   status, value_at_a, place_of_a
//  csr_*      in    active_size (write only)
//
// Each beat goes through latch and check, cell update, then result read-back.
// The next request is taken once the result is in the output register.
// A stalled response holds the read-back cycle until the register drains.
// Reset loads the identity into all cells and sets active_size to 64.
module permutation_table_with_inverse #(
   parameter int MAX_SIZE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   pti_req_if.sink                     req_bus,
   pti_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [pti_pkg::CFG_W-1:0]   csr_wdata
);

   // positions are 6 bits wide, so no entry above the 64th ever moves
   localparam int CELLS = (MAX_SIZE < pti_pkg::MAX_CELLS) ? MAX_SIZE : pti_pkg::MAX_CELLS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_READ
   } state_type;

   state_type                   state_ff, state_in;
   logic [pti_pkg::CFG_W-1:0]   size_ff;
   pti_pkg::upd_kind_type       kind_ff, kind_in;
   pti_pkg::pos_type            a_ff, a_in;
   pti_pkg::pos_type            b_ff, b_in;
   pti_pkg::status_type         st_ff, st_in;
   logic                        aok_ff, aok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pti_pkg::status_type         rsp_st_ff, rsp_st_in;
   pti_pkg::val_type            rsp_val_ff, rsp_val_in;
   pti_pkg::pos_type            rsp_place_ff, rsp_place_in;

   pti_pkg::val_type            fwd_row [CELLS];
   pti_pkg::val_type            inv_row [CELLS];
   pti_pkg::val_type            fwd_a, fwd_b, inv_a;
   pti_pkg::upd_type            upd;
   logic                        req_a_ok, req_b_ok;

   assign req_a_ok = ({1'b0, req_bus.pos_a} < size_ff) && (int'(req_bus.pos_a) < MAX_SIZE);
   assign req_b_ok = ({1'b0, req_bus.pos_b} < size_ff) && (int'(req_bus.pos_b) < MAX_SIZE);

   pti_select #(.CELLS(CELLS)) u_sel_fa (.sel(a_ff), .vals(fwd_row), .val(fwd_a));
   pti_select #(.CELLS(CELLS)) u_sel_fb (.sel(b_ff), .vals(fwd_row), .val(fwd_b));
   pti_select #(.CELLS(CELLS)) u_sel_ia (.sel(a_ff), .vals(inv_row), .val(inv_a));

   always_comb begin
      upd.kind  = (state_ff == S_UPDATE) ? kind_ff : pti_pkg::UPD_NONE;
      upd.a     = a_ff;
      upd.b     = b_ff;
      upd.fwd_a = fwd_a;
      upd.fwd_b = fwd_b;
   end

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      pti_pkg::val_type nbr;
      if (k + 1 < CELLS) begin : g_mid
         assign nbr = fwd_row[k+1];
      end else begin : g_end
         assign nbr = '0;
      end
      pti_cell #(.IDX(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .upd      (upd),
         .fwd_next (nbr),
         .fwd      (fwd_row[k]),
         .inv      (inv_row[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      st_in        = st_ff;
      aok_in       = aok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_place_in = rsp_place_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               a_in     = req_bus.pos_a;
               b_in     = req_bus.pos_b;
               aok_in   = req_a_ok;
               kind_in  = pti_pkg::UPD_NONE;
               st_in    = pti_pkg::ST_DONE;
               unique case (pti_pkg::req_kind_type'(req_bus.req_type))
                  pti_pkg::REQ_INIT: kind_in = pti_pkg::UPD_INIT;
                  pti_pkg::REQ_SWAP: begin
                     if (req_a_ok && req_b_ok) kind_in = pti_pkg::UPD_SWAP;
                     else st_in = pti_pkg::ST_RANGE;
                  end
                  pti_pkg::REQ_MOVE: begin
                     if (!(req_a_ok && req_b_ok)) st_in = pti_pkg::ST_RANGE;
                     else if (req_bus.pos_a >= req_bus.pos_b) st_in = pti_pkg::ST_ORDER;
                     else kind_in = pti_pkg::UPD_MOVE;
                  end
                  pti_pkg::REQ_QUERY: begin
                     if (!req_a_ok) st_in = pti_pkg::ST_RANGE;
                  end
                  default: st_in = pti_pkg::ST_DONE;
               endcase
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: state_in = S_READ;
         S_READ: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = st_ff;
               rsp_val_in   = aok_ff ? fwd_a : '0;
               rsp_place_in = aok_ff ? inv_a : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= pti_pkg::ACTIVE_SIZE_RESET;
         kind_ff      <= pti_pkg::UPD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) size_ff <= csr_wdata;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      st_ff        <= st_in;
      aok_ff       <= aok_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_place_ff <= rsp_place_in;
   end

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_st_ff;
   assign rsp_bus.value_at_a = rsp_val_ff;
   assign rsp_bus.place_of_a = rsp_place_ff;

endmodule

FILE: rtl/pti_cell.sv
// One position of the permutation: forward entry and inverse entry.
// Depends on pti_pkg; forward entry is handed to the lower neighbour.
module pti_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  pti_pkg::upd_type  upd,
   input  pti_pkg::val_type  fwd_next,
   output pti_pkg::val_type  fwd,
   output pti_pkg::pos_type  inv
);

   localparam pti_pkg::pos_type K = pti_pkg::POS_W'(IDX);

   pti_pkg::val_type fwd_ff, fwd_in;
   pti_pkg::pos_type inv_ff, inv_in;

   always_comb begin
      fwd_in = fwd_ff;
      inv_in = inv_ff;
      unique case (upd.kind)
         pti_pkg::UPD_INIT: begin
            fwd_in = K;
            inv_in = K;
         end
         pti_pkg::UPD_SWAP: begin
            if (K == upd.a) fwd_in = upd.fwd_b;
            else if (K == upd.b) fwd_in = upd.fwd_a;
            if (inv_ff == upd.a) inv_in = upd.b;
            else if (inv_ff == upd.b) inv_in = upd.a;
         end
         pti_pkg::UPD_MOVE: begin
            if (K >= upd.a && K < upd.b) fwd_in = fwd_next;
            else if (K == upd.b) fwd_in = upd.fwd_a;
            if (inv_ff == upd.a) inv_in = upd.b;
            else if (inv_ff > upd.a && inv_ff <= upd.b) inv_in = inv_ff - 6'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= K;
         inv_ff <= K;
      end else begin
         fwd_ff <= fwd_in;
         inv_ff <= inv_in;
      end
   end

   assign fwd = fwd_ff;
   assign inv = inv_ff;

endmodule

FILE: rtl/pti_select.sv
// One-hot AND-OR pick of one cell entry by position.
// Depends on pti_pkg.
module pti_select #(
   parameter int CELLS = 64
) (
   input  pti_pkg::pos_type  sel,
   input  pti_pkg::val_type  vals [CELLS],
   output pti_pkg::val_type  val
);

   always_comb begin
      val = '0;
      for (int k = 0; k < CELLS; k++) begin
         if (sel == pti_pkg::POS_W'(k)) val = val | vals[k];
      end
   end

endmodule

FILE: rtl/pti_checker.sv
// Port-level checker for the permutation table, bound to the top level.
// Depends on pti_pkg and permutation_table_with_inverse_macros.svh.
`include "permutation_table_with_inverse_macros.svh"

module pti_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [pti_pkg::ST_W-1:0]   rsp_status,
   input pti_pkg::val_type           rsp_value,
   input pti_pkg::pos_type           rsp_place
);

   `PTI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_place),
      "response beat dropped or changed under stall")
   `PTI_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "request taken while one is in flight")
   `PTI_ASSERT_SAME(a_status_code, rsp_valid, rsp_status <= pti_pkg::ST_ORDER,
      "undefined status code")
   `PTI_ASSERT_ALWAYS(a_reset_clears, $past(reset) && !reset, !rsp_valid,
      "response valid straight after reset")

endmodule

bind permutation_table_with_inverse pti_checker u_pti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_value  (rsp_bus.value_at_a),
   .rsp_place  (rsp_bus.place_of_a)
);

FILE: tb/permutation_table_with_inverse_test.sv
// Testbench for permutation_table_with_inverse: swap, move, reinit and query requests
// checked beat by beat against a local copy of the forward and inverse maps.
// Depends on pti_pkg, pti_channels and the block itself.
module permutation_table_with_inverse_test;
   import pti_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int CHOKE_CYCLES = 300;

   typedef struct packed {
      status_type st;
      val_type    val;
      pos_type    place;
   } map_reading_type;

   typedef struct {
      bit               is_cfg;
      logic [CFG_W-1:0] size;
      req_kind_type     kind;
      pos_type          a;
      pos_type          b;
      int               gap;
   } plan_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   pti_req_if req_ch ();
   pti_rsp_if rsp_ch ();

   permutation_table_with_inverse i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // local copy of the maps and the size register
   val_type          perm_fwd [MAX_CELLS];
   pos_type          perm_inv [MAX_CELLS];
   logic [CFG_W-1:0] size_reg = ACTIVE_SIZE_RESET;

   plan_entry_type  plan [$];
   map_reading_type expected_readings [$];
   int beats_sent = 0;
   int results_seen = 0;
   int fail_count = 0;
   int plan_count = 0;
   int sender_wait = 0;
   int rsp_hold = 0;
   int choke_left = 0;
   bit choke_done = 1'b0;
   int quiet_cycles = 0;
   int n_init = 0, n_swap = 0, n_move = 0, n_query = 0;
   int n_range = 0, n_order = 0, n_size_writes = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void load_identity_maps();
      for (int k = 0; k < MAX_CELLS; k++) begin
         perm_fwd[k] = val_type'(k);
         perm_inv[k] = pos_type'(k);
      end
   endfunction

   function automatic map_reading_type apply_request(req_kind_type kind, pos_type a,
                                                     pos_type b);
      map_reading_type r;
      int              eff;
      bit              a_ok, b_ok;
      val_type         va, vb, moved;
      eff  = (size_reg > MAX_CELLS) ? MAX_CELLS : int'(size_reg);
      a_ok = int'(a) < eff;
      b_ok = int'(b) < eff;
      r.st = ST_DONE;
      case (kind)
         REQ_INIT: begin
            load_identity_maps();
            n_init++;
         end
         REQ_SWAP: begin
            n_swap++;
            if (a_ok && b_ok) begin
               va = perm_fwd[a];
               vb = perm_fwd[b];
               perm_fwd[a] = vb;
               perm_fwd[b] = va;
               perm_inv[va] = b;
               perm_inv[vb] = a;
            end else begin
               r.st = ST_RANGE;
            end
         end
         REQ_MOVE: begin
            n_move++;
            if (!(a_ok && b_ok)) begin
               r.st = ST_RANGE;
            end else if (a >= b) begin
               r.st = ST_ORDER;
            end else begin
               moved = perm_fwd[a];
               for (int k = a; k < b; k++) begin
                  perm_fwd[k] = perm_fwd[k + 1];
                  perm_inv[perm_fwd[k]] = pos_type'(k);
               end
               perm_fwd[b] = moved;
               perm_inv[moved] = b;
            end
         end
         default: begin
            n_query++;
            if (!a_ok) r.st = ST_RANGE;
         end
      endcase
      if (r.st == ST_RANGE) n_range++;
      if (r.st == ST_ORDER) n_order++;
      r.val   = a_ok ? perm_fwd[a] : '0;
      r.place = a_ok ? perm_inv[a] : '0;
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("beat %0d: %s", results_seen, what);
      fail_count++;
   endtask

   task automatic add_req(req_kind_type kind, pos_type a, pos_type b);
      plan_entry_type e;
      e.is_cfg = 1'b0;
      e.size   = '0;
      e.kind   = kind;
      e.a      = a;
      e.b      = b;
      // every third stretch of 150 beats runs without sender gaps
      e.gap    = ((plan_count / 150) % 3 == 2) ? 0 : $urandom_range(10, 0);
      plan_count++;
      plan.insert(plan.size(), e);
   endtask

   task automatic add_cfg(int size);
      plan_entry_type e;
      e.is_cfg = 1'b1;
      e.size   = CFG_W'(size);
      e.kind   = REQ_QUERY;
      e.a      = '0;
      e.b      = '0;
      e.gap    = 0;
      plan.insert(plan.size(), e);
   endtask

   function automatic pos_type pick_pos(int n);
      if (n > 0 && $urandom_range(99, 0) < 92) return pos_type'($urandom_range(n - 1, 0));
      return pos_type'($urandom_range(63, 0));
   endfunction

   task automatic add_random_req(int n);
      int           roll;
      pos_type      a, b;
      req_kind_type kind;
      roll = $urandom_range(99, 0);
      if (roll < 3) kind = REQ_INIT;
      else if (roll < 38) kind = REQ_SWAP;
      else if (roll < 75) kind = REQ_MOVE;
      else kind = REQ_QUERY;
      a = pick_pos(n);
      b = pick_pos(n);
      if (kind == REQ_MOVE && n >= 2 && $urandom_range(99, 0) < 85) begin
         a = pos_type'($urandom_range(n - 2, 0));
         b = pos_type'($urandom_range(n - 1, a + 1));
      end
      add_req(kind, a, b);
   endtask

   // driver: offers queued beats and performs size writes once the block is drained
   always @(posedge clock) begin
      logic           valid_next;
      logic           we_next;
      plan_entry_type head;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_we       <= 1'b0;
         sender_wait = 0;
      end else begin
         valid_next = req_ch.valid;
         we_next    = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            expected_readings.insert(expected_readings.size(),
                                     apply_request(req_kind_type'(req_ch.req_type),
                                                   req_ch.pos_a, req_ch.pos_b));
            beats_sent <= beats_sent + 1;
            valid_next = 1'b0;
         end
         if (!valid_next && plan.size() > 0) begin
            head = plan[0];
            if (head.is_cfg) begin
               if (!req_ch.valid && !csr_we && beats_sent == results_seen) begin
                  we_next = 1'b1;
                  csr_wdata <= head.size;
                  size_reg = head.size;
                  n_size_writes++;
                  void'(plan.pop_front());
               end
            end else if (sender_wait < head.gap) begin
               sender_wait++;
            end else begin
               req_ch.req_type <= head.kind;
               req_ch.pos_a    <= head.a;
               req_ch.pos_b    <= head.b;
               valid_next = 1'b1;
               sender_wait = 0;
               void'(plan.pop_front());
            end
         end
         req_ch.valid <= valid_next;
         csr_we       <= we_next;
      end
   end

   // monitor: checks each result beat against the oldest expected reading
   always @(posedge clock) begin
      map_reading_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_seen >= beats_sent) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               want = expected_readings.pop_front();
               if (rsp_ch.status !== want.st)
                  flag_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.st));
               if (rsp_ch.value_at_a !== want.val)
                  flag_mismatch($sformatf("value_at_a got %0d want %0d",
                                          rsp_ch.value_at_a, want.val));
               if (rsp_ch.place_of_a !== want.place)
                  flag_mismatch($sformatf("place_of_a got %0d want %0d",
                                          rsp_ch.place_of_a, want.place));
            end
            results_seen <= results_seen + 1;
            rsp_hold = ((results_seen / 120) % 3 == 1) ? 0 : $urandom_range(10, 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ch.ready <= (rsp_hold == 0) && (choke_left == 0);
      end
   end

   // one long receiver hold-off so the block backs up onto its input
   always @(posedge clock) begin
      if (!reset && !choke_done && results_seen == 400) begin
         choke_left <= CHOKE_CYCLES;
         choke_done <= 1'b1;
      end else if (choke_left > 0) begin
         choke_left <= choke_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int sz, n, count;
      req_ch.valid    = 1'b0;
      req_ch.req_type = '0;
      req_ch.pos_a    = '0;
      req_ch.pos_b    = '0;
      rsp_ch.ready    = 1'b0;
      load_identity_maps();

      // directed: extremes, each request kind, range and order rejects, odd sizes
      add_req(REQ_QUERY, 6'd0, 6'd63);
      add_req(REQ_QUERY, 6'd63, 6'd0);
      add_req(REQ_SWAP, 6'd0, 6'd63);
      add_req(REQ_QUERY, 6'd63, 6'd63);
      add_req(REQ_MOVE, 6'd0, 6'd63);
      add_req(REQ_MOVE, 6'd5, 6'd5);
      add_req(REQ_MOVE, 6'd9, 6'd3);
      add_req(REQ_SWAP, 6'd7, 6'd7);
      add_req(REQ_INIT, 6'd0, 6'd0);
      add_cfg(10);
      add_req(REQ_SWAP, 6'd3, 6'd12);
      add_req(REQ_QUERY, 6'd10, 6'd0);
      add_req(REQ_MOVE, 6'd2, 6'd11);
      add_req(REQ_MOVE, 6'd1, 6'd9);
      add_req(REQ_INIT, 6'd40, 6'd1);
      add_req(REQ_MOVE, 6'd1, 6'd9);
      add_req(REQ_QUERY, 6'd9, 6'd0);
      add_cfg(0);
      add_req(REQ_QUERY, 6'd0, 6'd0);
      add_req(REQ_SWAP, 6'd0, 6'd0);
      add_req(REQ_INIT, 6'd0, 6'd0);
      add_cfg(127);
      add_req(REQ_SWAP, 6'd62, 6'd63);
      add_req(REQ_QUERY, 6'd63, 6'd0);
      add_req(REQ_MOVE, 6'd0, 6'd63);

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: sz = 64;
            1: sz = 1;
            2: sz = 127;
            3: sz = 0;
            4: sz = 2;
            5: sz = 65;
            10: sz = 64;
            11: sz = $urandom_range(127, 1);
            default: sz = $urandom_range(63, 3);
         endcase
         add_cfg(sz);
         n = (sz > MAX_CELLS) ? MAX_CELLS : sz;
         count = (n <= 2) ? 40 : 112;
         for (int i = 0; i < count; i++) add_random_req(n);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(plan.size() == 0 && !req_ch.valid && results_seen == beats_sent))
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d beats: %0d reinit, %0d swap, %0d move, %0d query, %0d size writes",
               beats_sent, n_init, n_swap, n_move, n_query, n_size_writes);
      $display("%0d range rejects, %0d backward moves, %0d mismatches",
               n_range, n_order, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: permutation_table_with_inverse.f
+incdir+rtl
rtl/pti_pkg.sv
rtl/pti_channels.sv
rtl/pti_cell.sv
rtl/pti_select.sv
rtl/permutation_table_with_inverse.sv
rtl/pti_checker.sv
tb/permutation_table_with_inverse_test.sv
